// ===== sv/tvr_pkg.sv =====
// tvr_pkg: shared types, key and register codes, fixed-point constants and helper
// functions for the teleop velocity ramp
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package tvr_pkg;

   // fixed point
   localparam int FRAC_BITS = 16;
   localparam int OUT_W     = 28;
   localparam int LIM_W     = 21;
   localparam int RAMP_W    = LIM_W + 1;  // |ramp| never exceeds the limit cap
   localparam int STEP_W    = 16;
   localparam int IDLE_W    = 4;
   localparam int KEY_W     = 5;
   localparam int CNT_W     = 9;

   localparam logic [LIM_W-1:0] LIMIT_CAP      = LIM_W'(16 << FRAC_BITS);
   localparam logic [LIM_W-1:0] LIMIT_FWD_INIT = LIM_W'(((1 << FRAC_BITS) * 2 + 5) / 10);
   localparam logic [LIM_W-1:0] LIMIT_TURN_INIT = LIM_W'(1 << FRAC_BITS);

   // divide by ten: multiply by ceil(2^27/10), exact for values below 2^24
   localparam int               PROD_W     = 24;
   localparam int               DIV_SHIFT  = 27;
   localparam logic [PROD_W-1:0] DIV10_MUL = PROD_W'(((64'd1 << DIV_SHIFT) + 9) / 10);

   // reset sequence phase bounds
   localparam logic [CNT_W-1:0] RESET_PHASE1 = CNT_W'(150);
   localparam logic [CNT_W-1:0] RESET_PHASE2 = CNT_W'(300);
   localparam logic [CNT_W-1:0] RESET_END    = CNT_W'(450);

   localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

   // key codes
   localparam logic [KEY_W-1:0] KEY_NONE       = 5'd0;
   localparam logic [KEY_W-1:0] KEY_STOP       = 5'd1;
   localparam logic [KEY_W-1:0] KEY_FWD        = 5'd2;
   localparam logic [KEY_W-1:0] KEY_BACK       = 5'd3;
   localparam logic [KEY_W-1:0] KEY_LEFT       = 5'd4;
   localparam logic [KEY_W-1:0] KEY_RIGHT      = 5'd5;
   localparam logic [KEY_W-1:0] KEY_FWD_LEFT   = 5'd6;
   localparam logic [KEY_W-1:0] KEY_FWD_RIGHT  = 5'd7;
   localparam logic [KEY_W-1:0] KEY_BACK_RIGHT = 5'd8;
   localparam logic [KEY_W-1:0] KEY_BACK_LEFT  = 5'd9;
   localparam logic [KEY_W-1:0] KEY_SIDE_POS   = 5'd10;
   localparam logic [KEY_W-1:0] KEY_SIDE_NEG   = 5'd11;
   localparam logic [KEY_W-1:0] KEY_FWD_UP     = 5'd12;
   localparam logic [KEY_W-1:0] KEY_FWD_DOWN   = 5'd13;
   localparam logic [KEY_W-1:0] KEY_SIDE_UP    = 5'd14;
   localparam logic [KEY_W-1:0] KEY_SIDE_DOWN  = 5'd15;
   localparam logic [KEY_W-1:0] KEY_TURN_UP    = 5'd16;
   localparam logic [KEY_W-1:0] KEY_TURN_DOWN  = 5'd17;
   localparam logic [KEY_W-1:0] KEY_BRAKE      = 5'd18;
   localparam logic [KEY_W-1:0] KEY_RESET      = 5'd19;

   // operation codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_LATCH = 1'b1;

   // register indexes
   typedef enum logic [1:0] {
      CSR_GUI_ENABLE   = 2'd0,
      CSR_LINEAR_STEP  = 2'd1,
      CSR_ANGULAR_STEP = 2'd2,
      CSR_IDLE_LIMIT   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_RAMP  = 2'd0,
      KIND_BRAKE = 2'd1,
      KIND_RESET = 2'd2
   } kind_type;

   typedef struct packed {
      logic               gui_enable;
      logic [STEP_W-1:0]  linear_step;
      logic [STEP_W-1:0]  angular_step;
      logic [IDLE_W-1:0]  idle_limit;
   } cfg_type;

   // per-axis direction, -1/0/+1
   typedef struct packed {
      logic signed [1:0] fwd;
      logic signed [1:0] turn;
      logic signed [1:0] side;
   } dir3_type;

   typedef struct packed {
      kind_type                 kind;
      logic signed [OUT_W-1:0]  linear_x;
      logic signed [OUT_W-1:0]  linear_y;
      logic signed [OUT_W-1:0]  linear_z;
      logic signed [OUT_W-1:0]  angular_z;
      logic [LIM_W-1:0]         max_forward;
      logic [LIM_W-1:0]         max_turn;
      logic [LIM_W-1:0]         max_sideways;
   } rsp_type;

   // whole number to fixed point, saturated to the output width
   function automatic logic signed [OUT_W-1:0] fixed_of(input int whole);
      longint v;
      longint hi;
      longint lo;
      v  = longint'(whole) * (longint'(1) <<< FRAC_BITS);
      hi = (longint'(1) <<< (OUT_W - 1)) - 1;
      lo = -(longint'(1) <<< (OUT_W - 1));
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return OUT_W'(v);
   endfunction

   localparam logic signed [OUT_W-1:0] TWIST_BRAKE  = fixed_of(1000);
   localparam logic signed [OUT_W-1:0] TWIST_RESET  = fixed_of(100);
   localparam logic signed [OUT_W-1:0] LIFT_PHASE0  = fixed_of(120);
   localparam logic signed [OUT_W-1:0] LIFT_PHASE1  = fixed_of(-130);
   localparam logic signed [OUT_W-1:0] LIFT_PHASE2  = fixed_of(10);

   function automatic dir3_type move_dir(input logic [KEY_W-1:0] key);
      dir3_type d;
      d = '0;
      case (key)
         KEY_FWD:        d = '{fwd: 2'sd1,  turn: 2'sd0,  side: 2'sd0};
         KEY_BACK:       d = '{fwd: -2'sd1, turn: 2'sd0,  side: 2'sd0};
         KEY_LEFT:       d = '{fwd: 2'sd0,  turn: 2'sd1,  side: 2'sd0};
         KEY_RIGHT:      d = '{fwd: 2'sd0,  turn: -2'sd1, side: 2'sd0};
         KEY_FWD_LEFT:   d = '{fwd: 2'sd1,  turn: 2'sd1,  side: 2'sd0};
         KEY_FWD_RIGHT:  d = '{fwd: 2'sd1,  turn: -2'sd1, side: 2'sd0};
         KEY_BACK_RIGHT: d = '{fwd: -2'sd1, turn: -2'sd1, side: 2'sd0};
         KEY_BACK_LEFT:  d = '{fwd: -2'sd1, turn: 2'sd1,  side: 2'sd0};
         KEY_SIDE_POS:   d = '{fwd: 2'sd0,  turn: 2'sd0,  side: 2'sd1};
         KEY_SIDE_NEG:   d = '{fwd: 2'sd0,  turn: 2'sd0,  side: -2'sd1};
         default:        d = '0;
      endcase
      return d;
   endfunction

   // limit times direction
   function automatic logic signed [RAMP_W-1:0] to_target(input logic signed [1:0] dir,
                                                          input logic [LIM_W-1:0] lim);
      logic signed [RAMP_W-1:0] mag;
      mag = $signed({1'b0, lim});
      case (dir)
         2'sd1:   return mag;
         -2'sd1:  return -mag;
         default: return '0;
      endcase
   endfunction

   // move ramp toward target by at most step
   function automatic logic signed [RAMP_W-1:0] slew(input logic signed [RAMP_W-1:0] ramp,
                                                     input logic signed [RAMP_W-1:0] target,
                                                     input logic [STEP_W-1:0] step);
      logic signed [RAMP_W+1:0] r;
      logic signed [RAMP_W+1:0] t;
      logic signed [RAMP_W+1:0] s;
      logic signed [RAMP_W+1:0] up;
      logic signed [RAMP_W+1:0] dn;
      r  = (RAMP_W + 2)'(ramp);
      t  = (RAMP_W + 2)'(target);
      s  = $signed({{(RAMP_W + 2 - STEP_W){1'b0}}, step});
      up = r + s;
      dn = r - s;
      if (t > r) return (up < t) ? up[RAMP_W-1:0] : target;
      if (t < r) return (dn > t) ? dn[RAMP_W-1:0] : target;
      return target;
   endfunction

endpackage

`default_nettype wire

// ===== sv/tvr_csr.sv =====
// tvr_csr: configuration registers of the velocity ramp, written over the csr channel
// depends on tvr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tvr_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [tvr_pkg::STEP_W-1:0]   csr_data,
   output tvr_pkg::cfg_type                  cfg
);
   import tvr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_GUI_ENABLE:   cfg_in.gui_enable   = csr_data[0];
            CSR_LINEAR_STEP:  cfg_in.linear_step  = csr_data;
            CSR_ANGULAR_STEP: cfg_in.angular_step = csr_data;
            CSR_IDLE_LIMIT:   cfg_in.idle_limit   = csr_data[IDLE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gui_enable   <= 1'b1;
         cfg_ff.linear_step  <= STEP_W'(1311);
         cfg_ff.angular_step <= STEP_W'(6554);
         cfg_ff.idle_limit   <= IDLE_W'(4);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/tvr_core.sv =====
// tvr_core: ramp state registers and the one-pass step logic for a tick or key latch
// depends on tvr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tvr_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        item_valid,
   input  wire logic                        item_go,
   input  wire logic                        item_operation,
   input  wire logic [tvr_pkg::KEY_W-1:0]   item_key_code,
   input  wire tvr_pkg::cfg_type            cfg,
   output logic                             emit,
   output tvr_pkg::rsp_type                 result
);
   import tvr_pkg::*;

   logic [KEY_W-1:0]          held_key_ff,  held_key_in;
   dir3_type                  dir_ff,       dir_in;
   logic [LIM_W-1:0]          lim_fwd_ff,   lim_fwd_in;
   logic [LIM_W-1:0]          lim_turn_ff,  lim_turn_in;
   logic [LIM_W-1:0]          lim_side_ff,  lim_side_in;
   logic signed [RAMP_W-1:0]  ramp_fwd_ff,  ramp_fwd_in;
   logic signed [RAMP_W-1:0]  ramp_turn_ff, ramp_turn_in;
   logic signed [RAMP_W-1:0]  ramp_side_ff, ramp_side_in;
   logic [IDLE_W-1:0]         idle_ff,      idle_in;
   logic [CNT_W-1:0]          seq_cnt_ff,   seq_cnt_in;

   logic                      is_move, is_scale, is_stop, is_brake, is_reset;
   logic                      scale_up;
   logic [LIM_W-1:0]          scale_src;
   logic [PROD_W-1:0]         scale_sum;
   logic [2*PROD_W-1:0]       scale_prod;
   logic [LIM_W-1:0]          scale_quot;
   logic [LIM_W-1:0]          scale_new;
   logic [IDLE_W-1:0]         idle_sat;
   logic [CNT_W-1:0]          seq_next;
   logic signed [RAMP_W-1:0]  base_fwd, base_turn, base_side;

   assign emit = item_valid && (item_operation == OP_TICK) && cfg.gui_enable;

   assign is_reset = (held_key_ff == KEY_RESET);
   assign is_brake = (held_key_ff == KEY_BRAKE);
   assign is_stop  = (held_key_ff == KEY_STOP);
   assign is_move  = (held_key_ff >= KEY_FWD) && (held_key_ff <= KEY_SIDE_NEG);
   assign is_scale = (held_key_ff >= KEY_FWD_UP) && (held_key_ff <= KEY_TURN_DOWN);

   // scale by 1.1 or 0.9 with rounding: (lim*11+5)/10 or (lim*9+5)/10
   assign scale_up = (held_key_ff == KEY_FWD_UP) || (held_key_ff == KEY_SIDE_UP) ||
                     (held_key_ff == KEY_TURN_UP);

   always_comb begin
      case (held_key_ff)
         KEY_FWD_UP, KEY_FWD_DOWN:   scale_src = lim_fwd_ff;
         KEY_SIDE_UP, KEY_SIDE_DOWN: scale_src = lim_side_ff;
         default:                    scale_src = lim_turn_ff;
      endcase
   end

   assign scale_sum  = (PROD_W'(scale_src) << 3) + PROD_W'(scale_src) +
                       (scale_up ? (PROD_W'(scale_src) << 1) : '0) + PROD_W'(5);
   assign scale_prod = (2 * PROD_W)'(scale_sum) * (2 * PROD_W)'(DIV10_MUL);
   assign scale_quot = scale_prod[DIV_SHIFT +: LIM_W];
   assign scale_new  = (scale_quot > LIMIT_CAP) ? LIMIT_CAP : scale_quot;

   assign idle_sat = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + IDLE_W'(1);
   assign seq_next = seq_cnt_ff + CNT_W'(1);

   always_comb begin
      held_key_in  = held_key_ff;
      dir_in       = dir_ff;
      lim_fwd_in   = lim_fwd_ff;
      lim_turn_in  = lim_turn_ff;
      lim_side_in  = lim_side_ff;
      idle_in      = idle_ff;
      seq_cnt_in   = seq_cnt_ff;
      base_fwd     = ramp_fwd_ff;
      base_turn    = ramp_turn_ff;
      base_side    = ramp_side_ff;

      if (is_move) begin
         dir_in  = move_dir(held_key_ff);
         idle_in = '0;
      end else if (is_scale) begin
         case (held_key_ff)
            KEY_FWD_UP, KEY_FWD_DOWN:   lim_fwd_in  = scale_new;
            KEY_SIDE_UP, KEY_SIDE_DOWN: lim_side_in = scale_new;
            default:                    lim_turn_in = scale_new;
         endcase
         idle_in = '0;
      end else if (is_stop) begin
         dir_in    = '0;
         base_fwd  = '0;
         base_turn = '0;
         base_side = '0;
      end else begin
         idle_in = idle_sat;
         if (idle_sat > cfg.idle_limit) dir_in = '0;
      end

      ramp_fwd_in  = slew(base_fwd,  to_target(dir_in.fwd,  lim_fwd_in),  cfg.linear_step);
      ramp_turn_in = slew(base_turn, to_target(dir_in.turn, lim_turn_in), cfg.angular_step);
      ramp_side_in = slew(base_side, to_target(dir_in.side, lim_side_in), cfg.linear_step);

      // brake and reset leave the ramp state alone
      if (is_brake || is_reset) begin
         dir_in       = dir_ff;
         lim_fwd_in   = lim_fwd_ff;
         lim_turn_in  = lim_turn_ff;
         lim_side_in  = lim_side_ff;
         idle_in      = idle_ff;
         ramp_fwd_in  = ramp_fwd_ff;
         ramp_turn_in = ramp_turn_ff;
         ramp_side_in = ramp_side_ff;
      end
      if (is_reset) begin
         if (seq_next >= RESET_END) begin
            seq_cnt_in  = '0;
            held_key_in = KEY_NONE;
         end else begin
            seq_cnt_in = seq_next;
         end
      end
   end

   always_comb begin
      result.max_forward  = lim_fwd_in;
      result.max_turn     = lim_turn_in;
      result.max_sideways = lim_side_in;
      if (is_reset) begin
         result.kind      = KIND_RESET;
         result.linear_x  = TWIST_RESET;
         result.linear_y  = TWIST_RESET;
         result.angular_z = TWIST_RESET;
         if (seq_cnt_ff < RESET_PHASE1)      result.linear_z = LIFT_PHASE0;
         else if (seq_cnt_ff < RESET_PHASE2) result.linear_z = LIFT_PHASE1;
         else                                result.linear_z = LIFT_PHASE2;
      end else if (is_brake) begin
         result.kind      = KIND_BRAKE;
         result.linear_x  = TWIST_BRAKE;
         result.linear_y  = TWIST_BRAKE;
         result.angular_z = TWIST_BRAKE;
         result.linear_z  = '0;
      end else begin
         result.kind      = KIND_RAMP;
         result.linear_x  = OUT_W'(ramp_fwd_in);
         result.linear_y  = OUT_W'(ramp_side_in);
         result.angular_z = OUT_W'(ramp_turn_in);
         result.linear_z  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_key_ff  <= KEY_NONE;
         dir_ff       <= '0;
         lim_fwd_ff   <= LIMIT_FWD_INIT;
         lim_turn_ff  <= LIMIT_TURN_INIT;
         lim_side_ff  <= LIMIT_FWD_INIT;
         ramp_fwd_ff  <= '0;
         ramp_turn_ff <= '0;
         ramp_side_ff <= '0;
         idle_ff      <= '0;
         seq_cnt_ff   <= '0;
      end else if (item_go) begin
         if (item_operation == OP_LATCH) begin
            held_key_ff <= item_key_code;
         end else if (emit) begin
            held_key_ff  <= held_key_in;
            dir_ff       <= dir_in;
            lim_fwd_ff   <= lim_fwd_in;
            lim_turn_ff  <= lim_turn_in;
            lim_side_ff  <= lim_side_in;
            ramp_fwd_ff  <= ramp_fwd_in;
            ramp_turn_ff <= ramp_turn_in;
            ramp_side_ff <= ramp_side_in;
            idle_ff      <= idle_in;
            seq_cnt_ff   <= seq_cnt_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/teleop_velocity_ramp.sv =====
// teleop_velocity_ramp: three-axis slew-limited velocity command generator, top level
// depends on tvr_pkg, tvr_csr, tvr_core
//
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    req_operation, req_key_code
// rsp      out        rsp_valid/rsp_ready    rsp_command_kind, twist, speed maxima
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// one item per cycle sustained while the result side accepts; a tick passes the input register,
// then step logic into the result register
// latch items and ticks with gui mode off give no result and pass straight through
// a held result stalls only the input stage; csr_ready is always high
// reset is synchronous and restores the power-up limits, ramps and configuration registers
`timescale 1ns / 1ps
`default_nettype none

module teleop_velocity_ramp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_operation,
   input  wire logic [tvr_pkg::KEY_W-1:0]          req_key_code,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [1:0]                              rsp_command_kind,
   output logic signed [tvr_pkg::OUT_W-1:0]        rsp_linear_x,
   output logic signed [tvr_pkg::OUT_W-1:0]        rsp_linear_y,
   output logic signed [tvr_pkg::OUT_W-1:0]        rsp_linear_z,
   output logic signed [tvr_pkg::OUT_W-1:0]        rsp_angular_z,
   output logic [tvr_pkg::LIM_W-1:0]               rsp_max_forward,
   output logic [tvr_pkg::LIM_W-1:0]               rsp_max_turn,
   output logic [tvr_pkg::LIM_W-1:0]               rsp_max_sideways,
   // configuration channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [tvr_pkg::STEP_W-1:0]         csr_data
);
   import tvr_pkg::*;

   cfg_type           cfg;

   // input register
   logic              s0_valid_ff, s0_valid_in;
   logic              s0_op_ff;
   logic [KEY_W-1:0]  s0_key_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   logic              emit;
   logic              s0_go;
   rsp_type           step_result;

   tvr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tvr_core u_core (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (s0_valid_ff),
      .item_go        (s0_go),
      .item_operation (s0_op_ff),
      .item_key_code  (s0_key_ff),
      .cfg            (cfg),
      .emit           (emit),
      .result         (step_result)
   );

   // the staged item moves on unless it has a result and the result slot stays full
   assign s0_go     = s0_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s0_valid_ff || s0_go;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (req_valid && req_ready) s0_valid_in = 1'b1;
      else if (s0_go)             s0_valid_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s0_go && emit)  rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s0_op_ff  <= req_operation;
         s0_key_ff <= req_key_code;
      end
      if (s0_go && emit) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_kind = rsp_data_ff.kind;
   assign rsp_linear_x     = rsp_data_ff.linear_x;
   assign rsp_linear_y     = rsp_data_ff.linear_y;
   assign rsp_linear_z     = rsp_data_ff.linear_z;
   assign rsp_angular_z    = rsp_data_ff.angular_z;
   assign rsp_max_forward  = rsp_data_ff.max_forward;
   assign rsp_max_turn     = rsp_data_ff.max_turn;
   assign rsp_max_sideways = rsp_data_ff.max_sideways;

endmodule

`default_nettype wire

// ===== sv/tvr_checker.sv =====
// tvr_checker: port-level checks on the velocity ramp results, bound to the top level
// depends on tvr_pkg and teleop_velocity_ramp
`timescale 1ns / 1ps
`default_nettype none

module tvr_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic [1:0]                         rsp_command_kind,
   input  wire logic signed [tvr_pkg::OUT_W-1:0]   rsp_linear_x,
   input  wire logic signed [tvr_pkg::OUT_W-1:0]   rsp_linear_z,
   input  wire logic [tvr_pkg::LIM_W-1:0]          rsp_max_forward,
   input  wire logic [tvr_pkg::LIM_W-1:0]          rsp_max_turn,
   input  wire logic [tvr_pkg::LIM_W-1:0]          rsp_max_sideways
);
   import tvr_pkg::*;

   // a stalled result keeps its transfer payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_linear_x) &&
      $stable(rsp_command_kind) && $stable(rsp_max_forward))
      else $error("rsp payload changed while stalled");

   // ramped commands never drive the vertical field
   a_ramp_no_lift: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command_kind == KIND_RAMP) |-> (rsp_linear_z == '0))
      else $error("ramp result with nonzero linear_z");

   // brake carries the fixed twist
   a_brake_twist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command_kind == KIND_BRAKE) |-> (rsp_linear_x == TWIST_BRAKE))
      else $error("brake result with wrong twist");

   // speed maxima stay saturated
   a_limit_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_max_forward <= LIMIT_CAP) && (rsp_max_turn <= LIMIT_CAP) &&
      (rsp_max_sideways <= LIMIT_CAP))
      else $error("speed maximum above cap");

endmodule

bind teleop_velocity_ramp tvr_checker u_tvr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_command_kind (rsp_command_kind),
   .rsp_linear_x     (rsp_linear_x),
   .rsp_linear_z     (rsp_linear_z),
   .rsp_max_forward  (rsp_max_forward),
   .rsp_max_turn     (rsp_max_turn),
   .rsp_max_sideways (rsp_max_sideways)
);

`default_nettype wire

// ===== verif/teleop_velocity_ramp_tb.sv =====
// teleop_velocity_ramp_tb: self-checking testbench for the three-axis velocity ramp
// depends on tvr_pkg and teleop_velocity_ramp; a directed table, then random key sequences
// checked against an in-bench model of the ramp, limits, idle timeout and reset sequence
`timescale 1ns / 1ps

module teleop_velocity_ramp_tb;
   import tvr_pkg::*;

   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          SETTLE_CYCLES = 8;    // a result passes the input register, then the result register
   localparam int          UP_TENTHS     = 11;
   localparam int          DOWN_TENTHS   = 9;
   localparam logic [KEY_W-1:0] KEY_UNUSED_MAX = '1;  // highest unassigned key code

   // power-up maxima: 0.2 rounded, and 1.0
   localparam logic [LIM_W-1:0] FWD_LIMIT_AT_RESET  = LIM_W'(((1 << FRAC_BITS) * 2 + 5) / 10);
   localparam logic [LIM_W-1:0] TURN_LIMIT_AT_RESET = LIM_W'(1 << FRAC_BITS);

   // fixed twists, far inside the 28-bit range so no saturation applies
   localparam logic signed [OUT_W-1:0] BRAKE_TWIST = OUT_W'(1000 * (1 << FRAC_BITS));
   localparam logic signed [OUT_W-1:0] RESET_TWIST = OUT_W'(100 * (1 << FRAC_BITS));
   localparam logic signed [OUT_W-1:0] LIFT_START  = OUT_W'(120 * (1 << FRAC_BITS));
   localparam logic signed [OUT_W-1:0] LIFT_MIDDLE = OUT_W'(-130 * (1 << FRAC_BITS));
   localparam logic signed [OUT_W-1:0] LIFT_END    = OUT_W'(10 * (1 << FRAC_BITS));

   // replies that can be read off directly after reset
   localparam rsp_type NOT_TYPED = '0;
   localparam rsp_type IDLE_REPLY = '{kind: KIND_RAMP, linear_x: '0, linear_y: '0,
      linear_z: '0, angular_z: '0, max_forward: FWD_LIMIT_AT_RESET,
      max_turn: TURN_LIMIT_AT_RESET, max_sideways: FWD_LIMIT_AT_RESET};
   localparam rsp_type BRAKE_REPLY = '{kind: KIND_BRAKE, linear_x: BRAKE_TWIST,
      linear_y: BRAKE_TWIST, linear_z: '0, angular_z: BRAKE_TWIST,
      max_forward: FWD_LIMIT_AT_RESET, max_turn: TURN_LIMIT_AT_RESET,
      max_sideways: FWD_LIMIT_AT_RESET};
   localparam rsp_type RESET_REPLY = '{kind: KIND_RESET, linear_x: RESET_TWIST,
      linear_y: RESET_TWIST, linear_z: LIFT_START, angular_z: RESET_TWIST,
      max_forward: FWD_LIMIT_AT_RESET, max_turn: TURN_LIMIT_AT_RESET,
      max_sideways: FWD_LIMIT_AT_RESET};

   typedef struct {
      logic             op;
      logic [KEY_W-1:0] key;
      bit               typed;
      rsp_type          want;
   } plan_row_type;

   localparam int PLAN_ROWS = 25;

   // directed table: typed rows carry their own reply, the rest go through the model
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{OP_TICK,  KEY_NONE,       1'b1, IDLE_REPLY},   // nothing held after reset
      '{OP_LATCH, KEY_BRAKE,      1'b0, NOT_TYPED},
      '{OP_TICK,  KEY_RESET,      1'b1, BRAKE_REPLY},  // tick ignores its own key field
      '{OP_LATCH, KEY_RESET,      1'b0, NOT_TYPED},
      '{OP_TICK,  KEY_UNUSED_MAX, 1'b1, RESET_REPLY},  // first tick of the reset sequence
      '{OP_LATCH, KEY_FWD,        1'b0, NOT_TYPED},
      '{OP_TICK,  KEY_NONE,       1'b0, NOT_TYPED},
      '{OP_LATCH, KEY_RESET,      1'b0, NOT_TYPED},
      '{OP_TICK,  KEY_STOP,       1'b1, RESET_REPLY},  // interrupted reset resumes
      '{OP_LATCH, KEY_FWD_RIGHT,  1'b0, NOT_TYPED},
      '{OP_TICK,  KEY_NONE,       1'b0, NOT_TYPED},
      '{OP_LATCH, KEY_BACK_LEFT,  1'b0, NOT_TYPED},
      '{OP_TICK,  KEY_NONE,       1'b0, NOT_TYPED},
      '{OP_LATCH, KEY_FWD_UP,     1'b0, NOT_TYPED},
      '{OP_TICK,  KEY_NONE,       1'b0, NOT_TYPED},
      '{OP_LATCH, KEY_TURN_DOWN,  1'b0, NOT_TYPED},
      '{OP_TICK,  KEY_NONE,       1'b0, NOT_TYPED},
      '{OP_LATCH, KEY_SIDE_POS,   1'b0, NOT_TYPED},
      '{OP_TICK,  KEY_NONE,       1'b0, NOT_TYPED},
      '{OP_LATCH, KEY_STOP,       1'b0, NOT_TYPED},
      '{OP_TICK,  KEY_NONE,       1'b0, NOT_TYPED},
      '{OP_LATCH, KEY_UNUSED_MAX, 1'b0, NOT_TYPED},  // unknown key acts as none
      '{OP_TICK,  KEY_NONE,       1'b0, NOT_TYPED},
      '{OP_LATCH, KEY_SIDE_NEG,   1'b0, NOT_TYPED},
      '{OP_TICK,  KEY_NONE,       1'b0, NOT_TYPED}
   };

   // dut signals, with every input driven to a known value from time zero
   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_operation = OP_TICK;
   logic [KEY_W-1:0]          req_key_code = KEY_NONE;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_command_kind;
   logic signed [OUT_W-1:0]   rsp_linear_x;
   logic signed [OUT_W-1:0]   rsp_linear_y;
   logic signed [OUT_W-1:0]   rsp_linear_z;
   logic signed [OUT_W-1:0]   rsp_angular_z;
   logic [LIM_W-1:0]          rsp_max_forward;
   logic [LIM_W-1:0]          rsp_max_turn;
   logic [LIM_W-1:0]          rsp_max_sideways;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index = CSR_GUI_ENABLE;
   logic [STEP_W-1:0]         csr_data = '0;

   // register copies, at their power-up values
   logic                      cfg_gui = 1'b1;
   logic [STEP_W-1:0]         cfg_lin_step = 16'd1311;
   logic [STEP_W-1:0]         cfg_ang_step = 16'd6554;
   logic [IDLE_W-1:0]         cfg_idle_limit = 4'd4;

   // model state
   logic [KEY_W-1:0]          held = KEY_NONE;
   logic signed [1:0]         dir_fwd = '0;
   logic signed [1:0]         dir_turn = '0;
   logic signed [1:0]         dir_side = '0;
   logic [LIM_W-1:0]          max_fwd = FWD_LIMIT_AT_RESET;
   logic [LIM_W-1:0]          max_turn = TURN_LIMIT_AT_RESET;
   logic [LIM_W-1:0]          max_side = FWD_LIMIT_AT_RESET;
   logic signed [OUT_W-1:0]   vel_fwd = '0;
   logic signed [OUT_W-1:0]   vel_turn = '0;
   logic signed [OUT_W-1:0]   vel_side = '0;
   logic [IDLE_W-1:0]         idle_count = '0;
   logic [CNT_W-1:0]          seq_count = '0;

   rsp_type                   awaited_twists [$];
   int                        mismatches = 0;
   int                        items_sent = 0;
   int                        sender_idle_pct = 0;
   int                        receiver_stall_pct = 0;
   int unsigned               cycle_count = 0;

   teleop_velocity_ramp DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_key_code     (req_key_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_kind (rsp_command_kind),
      .rsp_linear_x     (rsp_linear_x),
      .rsp_linear_y     (rsp_linear_y),
      .rsp_linear_z     (rsp_linear_z),
      .rsp_angular_z    (rsp_angular_z),
      .rsp_max_forward  (rsp_max_forward),
      .rsp_max_turn     (rsp_max_turn),
      .rsp_max_sideways (rsp_max_sideways),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("[teleop_velocity_ramp] ERROR");
      $finish;
   end

   // result side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // ---------------------------------------------------------------- model

   // scale a speed maximum by tenths, rounded, capped
   function automatic logic [LIM_W-1:0] rescale(input logic [LIM_W-1:0] lim,
                                                input int tenths);
      longint v;
      v = (longint'(lim) * tenths + 5) / 10;
      if (v > longint'(LIMIT_CAP)) v = longint'(LIMIT_CAP);
      return LIM_W'(v);
   endfunction

   // move one ramp toward its goal by at most one stride
   function automatic logic signed [OUT_W-1:0] approach(input longint cur,
                                                        input longint goal,
                                                        input longint stride);
      longint gap;
      gap = goal - cur;
      if (gap > stride) return OUT_W'(cur + stride);
      if (gap < -stride) return OUT_W'(cur - stride);
      return OUT_W'(goal);
   endfunction

   // advance the model by one accepted item; a twist comes out of every enabled tick
   task automatic predict_twist(input logic op, input logic [KEY_W-1:0] key,
                                output bit produced, output rsp_type twist);
      produced = 1'b0;
      twist = '0;
      if (op == OP_LATCH) begin
         held = key;
         return;
      end
      if (!cfg_gui) return;
      produced = 1'b1;
      if (held == KEY_RESET) begin
         // three lift phases by the count before it moves on
         twist.kind = KIND_RESET;
         twist.linear_x = RESET_TWIST;
         twist.linear_y = RESET_TWIST;
         twist.angular_z = RESET_TWIST;
         if (seq_count < RESET_PHASE1) twist.linear_z = LIFT_START;
         else if (seq_count < RESET_PHASE2) twist.linear_z = LIFT_MIDDLE;
         else twist.linear_z = LIFT_END;
         seq_count = seq_count + 1'b1;
         if (seq_count >= RESET_END) begin
            seq_count = '0;
            held = KEY_NONE;
         end
      end else if (held == KEY_BRAKE) begin
         twist.kind = KIND_BRAKE;
         twist.linear_x = BRAKE_TWIST;
         twist.linear_y = BRAKE_TWIST;
         twist.angular_z = BRAKE_TWIST;
      end else begin
         if (held >= KEY_FWD && held <= KEY_SIDE_NEG) begin
            case (held)
               KEY_FWD, KEY_FWD_LEFT, KEY_FWD_RIGHT:    dir_fwd = 2'sd1;
               KEY_BACK, KEY_BACK_LEFT, KEY_BACK_RIGHT: dir_fwd = -2'sd1;
               default:                                 dir_fwd = 2'sd0;
            endcase
            case (held)
               KEY_LEFT, KEY_FWD_LEFT, KEY_BACK_LEFT:    dir_turn = 2'sd1;
               KEY_RIGHT, KEY_FWD_RIGHT, KEY_BACK_RIGHT: dir_turn = -2'sd1;
               default:                                  dir_turn = 2'sd0;
            endcase
            case (held)
               KEY_SIDE_POS: dir_side = 2'sd1;
               KEY_SIDE_NEG: dir_side = -2'sd1;
               default:      dir_side = 2'sd0;
            endcase
            idle_count = '0;
         end else if (held >= KEY_FWD_UP && held <= KEY_TURN_DOWN) begin
            case (held)
               KEY_FWD_UP:    max_fwd = rescale(max_fwd, UP_TENTHS);
               KEY_FWD_DOWN:  max_fwd = rescale(max_fwd, DOWN_TENTHS);
               KEY_SIDE_UP:   max_side = rescale(max_side, UP_TENTHS);
               KEY_SIDE_DOWN: max_side = rescale(max_side, DOWN_TENTHS);
               KEY_TURN_UP:   max_turn = rescale(max_turn, UP_TENTHS);
               default:       max_turn = rescale(max_turn, DOWN_TENTHS);
            endcase
            idle_count = '0;
         end else if (held == KEY_STOP) begin
            // stop leaves the idle count alone
            dir_fwd = '0;
            dir_turn = '0;
            dir_side = '0;
            vel_fwd = '0;
            vel_turn = '0;
            vel_side = '0;
         end else begin
            // none or unknown key: count idle ticks, drop directions past the limit
            if (idle_count != IDLE_MAX) idle_count = idle_count + 1'b1;
            if (idle_count > cfg_idle_limit) begin
               dir_fwd = '0;
               dir_turn = '0;
               dir_side = '0;
            end
         end
         vel_fwd = approach(vel_fwd, longint'(max_fwd) * longint'(dir_fwd), cfg_lin_step);
         vel_turn = approach(vel_turn, longint'(max_turn) * longint'(dir_turn), cfg_ang_step);
         vel_side = approach(vel_side, longint'(max_side) * longint'(dir_side), cfg_lin_step);
         twist.kind = KIND_RAMP;
         twist.linear_x = vel_fwd;
         twist.linear_y = vel_side;
         twist.angular_z = vel_turn;
      end
      twist.max_forward = max_fwd;
      twist.max_turn = max_turn;
      twist.max_sideways = max_side;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // every result transfer is matched against the oldest awaited twist
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_twists.size() == 0) begin
            $error("result transfer with no twist awaited");
            mismatches++;
         end else begin
            want = awaited_twists.pop_front();
            check_field("command_kind", longint'(want.kind), longint'(rsp_command_kind));
            check_field("linear_x", longint'(want.linear_x), longint'(rsp_linear_x));
            check_field("linear_y", longint'(want.linear_y), longint'(rsp_linear_y));
            check_field("linear_z", longint'(want.linear_z), longint'(rsp_linear_z));
            check_field("angular_z", longint'(want.angular_z), longint'(rsp_angular_z));
            check_field("max_forward", longint'(want.max_forward), longint'(rsp_max_forward));
            check_field("max_turn", longint'(want.max_turn), longint'(rsp_max_turn));
            check_field("max_sideways", longint'(want.max_sideways),
                        longint'(rsp_max_sideways));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // one input transfer, with random idle cycles ahead of it
   task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                            input bit typed, input rsp_type want);
      bit      produced;
      rsp_type twist;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_key_code <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // transfer done at this edge
      items_sent++;
      predict_twist(op, key, produced, twist);
      if (produced) awaited_twists.push_back(typed ? want : twist);
   endtask

   // hold a key, then tick n times with junk in the key field
   task automatic tick_run(input logic [KEY_W-1:0] key, input int n);
      send_item(OP_LATCH, key, 1'b0, NOT_TYPED);
      repeat (n) send_item(OP_TICK, KEY_W'($urandom_range(KEY_UNUSED_MAX)), 1'b0, NOT_TYPED);
   endtask

   // stop sending, let every awaited twist arrive, then allow for in-flight no-result items
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_twists.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_transfer(input csr_index_type idx, input logic [STEP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_GUI_ENABLE:   cfg_gui = value[0];
         CSR_LINEAR_STEP:  cfg_lin_step = value;
         CSR_ANGULAR_STEP: cfg_ang_step = value;
         default:          cfg_idle_limit = value[IDLE_W-1:0];
      endcase
   endtask

   // all four registers back to back, valid held high across them
   task automatic load_settings(input logic gui, input logic [STEP_W-1:0] lin,
                                input logic [STEP_W-1:0] ang, input logic [IDLE_W-1:0] lim);
      csr_transfer(CSR_GUI_ENABLE, STEP_W'(gui));
      csr_transfer(CSR_LINEAR_STEP, lin);
      csr_transfer(CSR_ANGULAR_STEP, ang);
      csr_transfer(CSR_IDLE_LIMIT, STEP_W'(lim));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 45) return KEY_W'($urandom_range(KEY_SIDE_NEG, KEY_FWD));
      if (r < 65) return KEY_W'($urandom_range(KEY_TURN_DOWN, KEY_FWD_UP));
      if (r < 72) return KEY_STOP;
      if (r < 80) return KEY_BRAKE;
      if (r < 90) return KEY_NONE;
      return KEY_W'($urandom_range(KEY_UNUSED_MAX, KEY_RESET + 1));
   endfunction

   // mostly latch-then-tick sequences, some reset bursts, a little noise
   task automatic random_traffic(input int goal);
      int               start;
      int               r;
      logic [KEY_W-1:0] key;
      start = items_sent;
      while (items_sent - start < goal) begin
         r = $urandom_range(99);
         if (r < 8) begin
            // lone items: stray ticks, back-to-back latches
            send_item(logic'($urandom_range(1)), KEY_W'($urandom_range(KEY_UNUSED_MAX)),
                      1'b0, NOT_TYPED);
         end else if (r < 16) begin
            tick_run(KEY_RESET, $urandom_range(80, 1));
         end else begin
            key = pick_key();
            if (key == KEY_NONE || key > KEY_RESET) tick_run(key, $urandom_range(20, 1));
            else tick_run(key, $urandom_range(12, 1));
         end
         // now and then drain the pipe completely before going on
         if ($urandom_range(49) == 0) settle();
      end
   endtask

   // ---------------------------------------------------------------- run

   initial begin
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-up settings, no idling
      foreach (directed_plan[i])
         send_item(directed_plan[i].op, directed_plan[i].key, directed_plan[i].typed,
                   directed_plan[i].want);
      // the whole reset sequence through all three phases and its release
      tick_run(KEY_RESET, 460);
      random_traffic(200);

      for (phase = 1; phase < 8; phase++) begin
         settle();
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
            default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
         endcase
         case (phase)
            1: load_settings(1'b0, '0, '0, '0);     // ticks ignored, latches still land
            2: load_settings(1'b1, '0, '1, '0);
            3: load_settings(1'b1, '1, '0, '1);
            4: load_settings(1'b1, STEP_W'($urandom), STEP_W'($urandom),
                             IDLE_W'($urandom_range(IDLE_MAX)));
            5: load_settings(1'b1, STEP_W'($urandom_range(4000, 1)),
                             STEP_W'($urandom_range(20000, 1)),
                             IDLE_W'($urandom_range(IDLE_MAX)));
            6: load_settings(1'b1, STEP_W'($urandom), STEP_W'($urandom),
                             IDLE_W'($urandom_range(IDLE_MAX)));
            default: load_settings(1'b1, 16'd1311, 16'd6554, 4'd4);
         endcase
         random_traffic(phase == 1 ? 40 : 160);
      end

      settle();
      if (awaited_twists.size() != 0) begin
         $error("%0d twists never arrived", awaited_twists.size());
         mismatches++;
      end
      if (mismatches == 0) $display("[teleop_velocity_ramp] OK");
      else $display("[teleop_velocity_ramp] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tvr_pkg.sv
sv/tvr_csr.sv
sv/tvr_core.sv
sv/teleop_velocity_ramp.sv
sv/tvr_checker.sv
verif/teleop_velocity_ramp_tb.sv
